[rtl/lkv_pkg.sv]
// Shared types and constants for the LRU key/value cache.
`timescale 1ns / 1ps
`default_nettype none
package lkv_pkg;

  localparam int KEY_W     = 32;
  localparam int VALUE_W   = 64;
  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 64;
  localparam int M_TUSER_W = 2;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic ins;
    logic pro;
  } order_cmd_t;

endpackage
`default_nettype wire

[rtl/lkv_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module lkv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/lkv_order.sv]
// Valid bits, recency ranks and fill count of the cache entries.
`timescale 1ns / 1ps
`default_nettype none
module lkv_order
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int IW      = 3,
  parameter int RW      = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire order_cmd_t    cmd,
  input  wire logic [IW-1:0] sel_idx,
  input  wire logic [RW-1:0] sel_rank,
  input  wire logic [IW-1:0] rd_idx,
  output logic               rd_valid,
  output logic [RW-1:0]      rd_rank,
  output logic               full
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic          valid [ENTRIES];
  logic [RW-1:0] rank  [ENTRIES];
  logic [CW-1:0] count;

  assign full     = (count == CW'(ENTRIES));
  assign rd_valid = valid[rd_idx];
  assign rd_rank  = rank[rd_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid[i] <= 1'b0;
        rank[i]  <= '0;
      end
      count <= '0;
    end else begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (cmd.ins) begin
          if (IW'(i) == sel_idx) begin
            valid[i] <= 1'b1;
            rank[i]  <= '0;
          end else if (valid[i]) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end else if (cmd.pro) begin
          if (IW'(i) == sel_idx) begin
            rank[i] <= '0;
          end else if (valid[i] && rank[i] < sel_rank) begin
            rank[i] <= rank[i] + RW'(1);
          end
        end
      end
      if (cmd.ins && !full) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/lkv_seq.sv]
// Sequencer and shared entry compare unit that scans the cache one entry a cycle.
`timescale 1ns / 1ps
`default_nettype none
module lkv_seq
  import lkv_pkg::*;
#(
  parameter int ENTRIES = 8,
  parameter int KW      = 32,
  parameter int IW      = 3,
  parameter int RW      = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [KW-1:0]         in_key,
  input  wire logic                  in_type,
  input  wire logic [VALUE_W-1:0]    in_value,
  output logic [IW-1:0]              ram_raddr,
  input  wire logic [KW+VALUE_W:0]   ram_rdata,
  output logic                       ram_we,
  output logic [IW-1:0]              ram_waddr,
  output logic [KW+VALUE_W:0]        ram_wdata,
  output logic [IW-1:0]              ord_rd_idx,
  input  wire logic                  ord_rd_valid,
  input  wire logic [RW-1:0]         ord_rd_rank,
  input  wire logic                  ord_full,
  output order_cmd_t                 ord_cmd,
  output logic [IW-1:0]              ord_sel_idx,
  output logic [RW-1:0]              ord_sel_rank,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_hit,
  output logic [VALUE_W-1:0]         out_value,
  output logic                       out_evicted
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [IW-1:0] LAST_IDX  = IW'(ENTRIES - 1);
  localparam logic [RW-1:0] LAST_RANK = RW'(ENTRIES - 1);

  logic [1:0]         state;
  logic               op_r;
  logic [KW-1:0]      key_r;
  logic               type_r;
  logic [VALUE_W-1:0] value_r;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      idx_d;
  logic               issue_done;
  logic               pv;
  logic               found;
  logic [IW-1:0]      best_idx;
  logic [RW-1:0]      best_rank;
  logic [VALUE_W-1:0] best_value;

  logic [KW-1:0]      rd_key;
  logic               rd_type;
  logic [VALUE_W-1:0] rd_value;
  logic               key_eq;
  logic               take;
  logic               finish_go;

  assign rd_key   = ram_rdata[KW-1:0];
  assign rd_type  = ram_rdata[KW];
  assign rd_value = ram_rdata[KW+VALUE_W:KW+1];

  assign key_eq = ord_rd_valid && (rd_key == key_r) && (rd_type == type_r);

  always_comb begin
    if (op_r == OP_GET) begin
      take = key_eq && (!found || (ord_rd_rank < best_rank));
    end else if (ord_full) begin
      take = ord_rd_valid && (ord_rd_rank == LAST_RANK);
    end else begin
      take = !ord_rd_valid && !found;
    end
  end

  assign in_ready   = (state == ST_IDLE);
  assign ram_raddr  = idx;
  assign ord_rd_idx = idx_d;
  assign finish_go  = (state == ST_FINISH) && (!out_valid || out_ready);

  assign ord_cmd.ins  = finish_go && (op_r == OP_ADD);
  assign ord_cmd.pro  = finish_go && (op_r == OP_GET) && found;
  assign ord_sel_idx  = best_idx;
  assign ord_sel_rank = best_rank;

  assign ram_we    = ord_cmd.ins;
  assign ram_waddr = best_idx;
  assign ram_wdata = {value_r, type_r, key_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      issue_done <= 1'b0;
      pv         <= 1'b0;
      found      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready && !finish_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_r       <= in_op;
            key_r      <= in_key;
            type_r     <= in_type;
            value_r    <= in_value;
            idx        <= '0;
            issue_done <= 1'b0;
            pv         <= 1'b0;
            found      <= 1'b0;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (!issue_done) begin
            pv    <= 1'b1;
            idx_d <= idx;
            if (idx == LAST_IDX) begin
              issue_done <= 1'b1;
            end else begin
              idx <= idx + IW'(1);
            end
          end else begin
            pv <= 1'b0;
          end
          if (pv) begin
            if (take) begin
              found      <= 1'b1;
              best_idx   <= idx_d;
              best_rank  <= ord_rd_rank;
              best_value <= rd_value;
            end
            if (idx_d == LAST_IDX) begin
              state <= ST_FINISH;
            end
          end
        end
        ST_FINISH: begin
          if (finish_go) begin
            out_valid   <= 1'b1;
            out_hit     <= (op_r == OP_GET) && found;
            out_value   <= ((op_r == OP_GET) && found) ? best_value : '0;
            out_evicted <= (op_r == OP_ADD) && ord_full;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/lru_key_value_cache_unit.sv]
// Top level of the LRU key/value cache with stream ports.
`timescale 1ns / 1ps
`default_nettype none
// A small least-recently-used key/value store. An add word stores a new entry as the most
// recent one without looking for an existing key; on a full store it first drops the least
// recent entry and reports evicted. A get word returns the value of the most recent entry
// whose key and value type both match, and makes that entry the most recent. Every input
// word gives exactly one result word. Entries live in one RAM with a single read port, and
// the sequencer reads one entry per cycle through a shared compare unit, so each word passes
// through capture, a scan of all entries, and a finish step that updates the order and loads
// the result register before the next word is accepted. The result register holds a
// finished word while the next input word is already being scanned.
module lru_key_value_cache_unit
  import lkv_pkg::*;
#(
  parameter int ENTRIES  = 8,
  parameter int KEY_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,  // key[31:0], value[95:32]
  input  wire logic [S_TUSER_W-1:0] s_tuser,  // operation[0], value_type[1]
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,  // value_out[63:0]
  output logic [M_TUSER_W-1:0]      m_tuser   // hit[0], evicted[1]
);

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = KW + VALUE_W + 1;

  logic [IW-1:0]      ram_raddr;
  logic [DW-1:0]      ram_rdata;
  logic               ram_we;
  logic [IW-1:0]      ram_waddr;
  logic [DW-1:0]      ram_wdata;
  logic [IW-1:0]      ord_rd_idx;
  logic               ord_rd_valid;
  logic [RW-1:0]      ord_rd_rank;
  logic               ord_full;
  order_cmd_t         ord_cmd;
  logic [IW-1:0]      ord_sel_idx;
  logic [RW-1:0]      ord_sel_rank;
  logic               out_hit;
  logic [VALUE_W-1:0] out_value;
  logic               out_evicted;

  lkv_ram #(
    .WIDTH(DW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  lkv_order #(
    .ENTRIES(ENTRIES),
    .IW     (IW),
    .RW     (RW)
  ) u_order (
    .clk     (clk),
    .rst     (rst),
    .cmd     (ord_cmd),
    .sel_idx (ord_sel_idx),
    .sel_rank(ord_sel_rank),
    .rd_idx  (ord_rd_idx),
    .rd_valid(ord_rd_valid),
    .rd_rank (ord_rd_rank),
    .full    (ord_full)
  );

  lkv_seq #(
    .ENTRIES(ENTRIES),
    .KW     (KW),
    .IW     (IW),
    .RW     (RW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_op       (s_tuser[0]),
    .in_key      (s_tdata[KW-1:0]),
    .in_type     (s_tuser[1]),
    .in_value    (s_tdata[KEY_W+VALUE_W-1:KEY_W]),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ord_rd_idx  (ord_rd_idx),
    .ord_rd_valid(ord_rd_valid),
    .ord_rd_rank (ord_rd_rank),
    .ord_full    (ord_full),
    .ord_cmd     (ord_cmd),
    .ord_sel_idx (ord_sel_idx),
    .ord_sel_rank(ord_sel_rank),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_hit     (out_hit),
    .out_value   (out_value),
    .out_evicted (out_evicted)
  );

  assign m_tdata = out_value;
  assign m_tuser = {out_evicted, out_hit};

endmodule
`default_nettype wire

[rtl/lkv_checker.sv]
// Port-level assertions for the LRU key/value cache and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lkv_checker
  import lkv_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 s_tvalid,
  input wire logic                 s_tready,
  input wire logic [S_TDATA_W-1:0] s_tdata,
  input wire logic [S_TUSER_W-1:0] s_tuser,
  input wire logic                 m_tvalid,
  input wire logic                 m_tready,
  input wire logic [M_TDATA_W-1:0] m_tdata,
  input wire logic [M_TUSER_W-1:0] m_tuser
);

  // A held result word keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed while stalled");

  // A word that misses, or an add, returns a zero value.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero value without a hit");

  // A get never evicts and an add never hits.
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("hit and evicted both set");

  // The block works on one word at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a word is in progress");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

endmodule

bind lru_key_value_cache_unit lkv_checker u_lkv_checker (.*);
`default_nettype wire

[bench/tb_lru_key_value_cache_unit.sv]
// Self-checking testbench for the LRU key/value cache with stream ports.
`timescale 1ns / 1ps
module tb_lru_key_value_cache_unit;
  import lkv_pkg::*;

  localparam int ENTRIES = 8;
  localparam int KEY_BITS = 32;
  localparam logic VT_INT = 1'b0;
  localparam logic VT_DOUBLE = 1'b1;
  localparam int RANDOM_WORDS = 1830;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hit;
    logic [63:0] value_out;
    logic        evicted;
  } cache_reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // key[31:0], value[95:32]
  logic [S_TUSER_W-1:0] s_tuser = '0;  // operation[0], value_type[1]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;  // value_out[63:0]
  logic [M_TUSER_W-1:0] m_tuser;  // hit[0], evicted[1]

  logic [31:0] shadow_key [ENTRIES];
  logic        shadow_type [ENTRIES];
  logic [63:0] shadow_value [ENTRIES];
  logic        shadow_valid [ENTRIES];
  int          shadow_rank [ENTRIES];
  int          shadow_fill;

  cache_reply_t pending_replies[$];
  int failures = 0;
  int words_sent = 0;
  int replies_seen = 0;
  int hits_predicted = 0;
  int misses_predicted = 0;
  int evictions_predicted = 0;
  int cycle_count = 0;
  int rx_stall = 0;
  bit quiet = 1'b0;
  logic [31:0] key_pool [16];
  int pool_size;

  lru_key_value_cache_unit #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d replies pending.", cycle_count,
               pending_replies.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic cache_reply_t predict_cache_reply(logic op, logic [31:0] key, logic vt,
                                                       logic [63:0] val);
    cache_reply_t r;
    int oldest;
    int slot;
    int found;
    int rank_found;
    r = '0;
    if (op == OP_ADD) begin
      if (shadow_fill >= ENTRIES) begin
        oldest = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && (oldest < 0 || shadow_rank[i] >= shadow_rank[oldest]))
            oldest = i;
        shadow_valid[oldest] = 1'b0;
        shadow_fill--;
        r.evicted = 1'b1;
      end
      slot = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (!shadow_valid[i] && slot < 0) slot = i;
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_valid[i]) shadow_rank[i]++;
      shadow_key[slot] = key;
      shadow_type[slot] = vt;
      shadow_value[slot] = val;
      shadow_valid[slot] = 1'b1;
      shadow_rank[slot] = 0;
      shadow_fill++;
    end else begin
      found = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (shadow_valid[i] && shadow_key[i] == key && shadow_type[i] == vt &&
            (found < 0 || shadow_rank[i] < shadow_rank[found]))
          found = i;
      if (found >= 0) begin
        r.hit = 1'b1;
        r.value_out = shadow_value[found];
        rank_found = shadow_rank[found];
        for (int i = 0; i < ENTRIES; i++)
          if (shadow_valid[i] && shadow_rank[i] < rank_found) shadow_rank[i]++;
        shadow_rank[found] = 0;
      end
    end
    return r;
  endfunction

  task automatic note_failure(string what);
    failures++;
    if (failures <= 10) $display("Mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  // Result side: random stalls on m_tready, and every accepted word is compared.
  always @(posedge clk) begin
    cache_reply_t want;
    if (rst) begin
      rx_stall = 0;
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        replies_seen++;
        if (pending_replies.size() == 0) begin
          note_failure($sformatf("unexpected word hit=%0b value=%h evicted=%0b",
                                 m_tuser[0], m_tdata, m_tuser[1]));
        end else begin
          want = pending_replies.pop_front();
          if (m_tuser[0] !== want.hit)
            note_failure($sformatf("hit expected %0b actual %0b", want.hit, m_tuser[0]));
          if (m_tdata !== want.value_out)
            note_failure($sformatf("value_out expected %h actual %h", want.value_out,
                                   m_tdata));
          if (m_tuser[1] !== want.evicted)
            note_failure($sformatf("evicted expected %0b actual %0b", want.evicted,
                                   m_tuser[1]));
        end
        rx_stall = quiet ? 0 : $urandom_range(0, 15);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      m_tready <= (rx_stall == 0);
    end
  end

  task automatic send_word(logic op, logic [31:0] key, logic vt, logic [63:0] val);
    int gap;
    cache_reply_t r;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {val, key};
    s_tuser <= {vt, op};
    do @(posedge clk); while (!s_tready);
    r = predict_cache_reply(op, key, vt, val);
    pending_replies.push_back(r);
    words_sent++;
    if (op == OP_GET) begin
      if (r.hit) hits_predicted++;
      else misses_predicted++;
    end
    if (r.evicted) evictions_predicted++;
  endtask

  task automatic test_extremes();
    send_word(OP_GET, 32'h0000_0000, VT_INT, 64'h0);
    send_word(OP_ADD, 32'h0000_0000, VT_INT, 64'h0);
    send_word(OP_ADD, 32'hFFFF_FFFF, VT_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_GET, 32'hFFFF_FFFF, VT_DOUBLE, 64'h0);
    send_word(OP_GET, 32'hFFFF_FFFF, VT_INT, 64'h0);
    send_word(OP_GET, 32'h0000_0000, VT_INT, 64'hFFFF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_duplicate_keys();
    send_word(OP_ADD, 32'h5A5A_0001, VT_INT, 64'h0123_4567_89AB_CDEF);
    send_word(OP_ADD, 32'h5A5A_0001, VT_INT, 64'hFEDC_BA98_7654_3210);
    send_word(OP_GET, 32'h5A5A_0001, VT_INT, 64'h0);
    send_word(OP_GET, 32'h5A5A_0001, VT_INT, 64'h0);
  endtask

  task automatic test_eviction();
    for (int i = 0; i < 4; i++)
      send_word(OP_ADD, 32'h0000_0100 + i, i[0], {$urandom, $urandom});
    send_word(OP_GET, 32'hFFFF_FFFF, VT_DOUBLE, 64'h0);
    send_word(OP_ADD, 32'h0000_0200, VT_INT, 64'h8000_0000_0000_0001);
    send_word(OP_GET, 32'h0000_0000, VT_INT, 64'h0);
    send_word(OP_ADD, 32'h0000_0201, VT_DOUBLE, 64'h7FF0_0000_0000_0000);
    send_word(OP_GET, 32'hFFFF_FFFF, VT_DOUBLE, 64'h0);
  endtask

  // Keys come mostly from a small pool so that gets hit, duplicates pile up and the
  // store overflows; the rest are fully random keys.
  task automatic test_random_traffic();
    logic op;
    logic [31:0] key;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 50 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
        pool_size = $urandom_range(2, 16);
        for (int k = 0; k < 16; k++)
          if ($urandom_range(0, 2) == 0) key_pool[k] = $urandom;
      end
      op = ($urandom_range(0, 1) == 0) ? OP_ADD : OP_GET;
      if ($urandom_range(0, 9) == 0) key = $urandom;
      else key = key_pool[$urandom_range(0, pool_size - 1)];
      send_word(op, key, 1'($urandom_range(0, 1)), {$urandom, $urandom});
    end
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end
    shadow_fill = 0;
    for (int k = 0; k < 16; k++) key_pool[k] = $urandom;
    pool_size = 12;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_duplicate_keys();
    test_eviction();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (4 * ENTRIES + 20) @(posedge clk);
    $display("Sent %0d words: %0d gets hit, %0d gets missed, %0d adds evicted an entry.",
             words_sent, hits_predicted, misses_predicted, evictions_predicted);
    $display("Checked %0d result words with random stalls on both sides.", replies_seen);
    if (failures == 0 && pending_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d replies missing.", failures, pending_replies.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
